// ----- hw/rtl/hrvws_pkg.sv -----
// Shared types and constants for the HRV window statistics block.
// No dependencies; the interfaces, the square root and the top module import this package.
`default_nettype none

package hrvws_pkg;

  // Field widths of the beat and statistics words
  localparam int BEAT_W  = 8;
  localparam int RESP_W  = 8;
  localparam int MEAN_W  = 15;
  localparam int SDNN_W  = 15;
  localparam int PNN_W   = 14;
  localparam int RMSSD_W = 15;

  // Configuration port
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam int THR_W   = 8;
  localparam logic [THR_W-1:0] THR_RESET = 8'd50;
  localparam logic REG_PNN_THR = 1'b0;  // word index of pnn_threshold

  // Arithmetic bounds and scale factors
  localparam int BEAT_MAX   = 255;
  localparam int SQ_MAX     = 65025;    // largest square of an 8-bit magnitude
  localparam int MEAN_SCALE = 100;
  localparam int PNN_SCALE  = 10000;
  localparam int RAD_SCALE  = 10000;
  localparam int QW         = 17;       // mean square quotient never exceeds SQ_MAX
  localparam int SQ_IN_W    = 30;       // RAD_SCALE * SQ_MAX fits in 30 bits
  localparam int SQ_OUT_W   = 15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS1,
    ST_DIV_Q,
    ST_DIV_MEAN,
    ST_PASS2,
    ST_DIV_SD,
    ST_SQRT_SD,
    ST_DIV_RM,
    ST_SQRT_RM,
    ST_DIV_PNN,
    ST_DONE
  } hrvws_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hrvws_if.sv -----
// Valid/ready channel interfaces for beat words in and statistics words out.
// Depends on hrvws_pkg for the field widths.
`default_nettype none

interface hrvws_in_if import hrvws_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BEAT_W-1:0] beat_value;
  logic [RESP_W-1:0] resp_rate;

  modport source (output valid, output beat_value, output resp_rate, input ready);
  modport sink   (input valid, input beat_value, input resp_rate, output ready);
endinterface

interface hrvws_out_if import hrvws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MEAN_W-1:0]  mean_x100;
  logic [SDNN_W-1:0]  sdnn_x100;
  logic [PNN_W-1:0]   pnn_x100;
  logic [RMSSD_W-1:0] rmssd_x100;
  logic [RESP_W-1:0]  resp_out;

  modport source (output valid, output mean_x100, output sdnn_x100, output pnn_x100,
                  output rmssd_x100, output resp_out, input ready);
  modport sink   (input valid, input mean_x100, input sdnn_x100, input pnn_x100,
                  input rmssd_x100, input resp_out, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/hrvws_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
`default_nettype none

module hrvws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 20
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hrvws_div.sv -----
// Divider by a fixed divisor, or by that divisor minus one, using reciprocal multiplication.
// Depends on nothing; widths and the divisor come from its parameters.
`default_nettype none

module hrvws_div #(
  parameter int DW      = 21,
  parameter int VW      = 5,
  parameter int DIVISOR = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic          by_m1,
  output logic               done,
  output logic      [DW-1:0] quotient,
  output logic      [VW-1:0] remainder
);

  // Reciprocal scaled by 2^SHIFT and rounded up; exact for every DW-bit dividend
  localparam int SHIFT = DW + $clog2(DIVISOR) + 1;
  localparam int MW    = DW + 3;
  localparam int PRW   = DW + MW;
  localparam logic [63:0] RECIP    = ((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
  localparam logic [63:0] RECIP_M1 = ((64'd1 << SHIFT) + 64'(DIVISOR - 2)) / 64'(DIVISOR - 1);

  logic [1:0]       stage;
  logic [DW-1:0]    dvd;
  logic             sel_m1;
  logic [MW-1:0]    recip;
  logic [VW-1:0]    dvs;
  logic [PRW-1:0]   prod;
  logic [DW+VW-1:0] back;

  always_comb begin
    recip = sel_m1 ? MW'(RECIP_M1) : MW'(RECIP);
    dvs   = sel_m1 ? VW'(DIVISOR - 1) : VW'(DIVISOR);
    prod  = PRW'(dvd) * PRW'(recip);
    back  = (DW+VW)'(quotient) * (DW+VW)'(dvs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[0], start};
      done  <= stage[1];
    end
  end

  // Latch the operand, then settle the quotient, then the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dvd    <= dividend;
      sel_m1 <= by_m1;
    end
    if (stage[0]) begin
      quotient <= DW'(prod >> SHIFT);
    end
    if (stage[1]) begin
      remainder <= VW'(dvd - back[DW-1:0]);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hrvws_isqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle, truncated.
// Depends on hrvws_pkg for the radicand and root widths.
`default_nettype none

module hrvws_isqrt import hrvws_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [SQ_IN_W-1:0]  radicand,
  output logic                     done,
  output logic      [SQ_OUT_W-1:0] root
);

  localparam int RW    = SQ_OUT_W + 1;          // partial remainder never exceeds 2*root
  localparam int CNT_W = $clog2(SQ_OUT_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   steps;
  logic [SQ_IN_W-1:0] rad;
  logic [RW-1:0]      rem;
  logic [RW+1:0]      cur;
  logic [RW+1:0]      trial;
  logic [RW+1:0]      diff;
  logic               fits;

  always_comb begin
    cur   = {rem, rad[SQ_IN_W-1 -: 2]};
    trial = (RW+2)'({root, 2'b01});
    diff  = cur - trial;
    fits  = cur >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNT_W'(SQ_OUT_W);
      end else if (busy) begin
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Bring down two radicand bits a step, settle one root bit
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[SQ_IN_W-3:0], 2'b00};
      rem  <= fits ? diff[RW-1:0] : cur[RW-1:0];
      root <= {root[SQ_OUT_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/hrv_window_statistics_unit.sv -----
// HRV window statistics: mean, SDNN, pNN and RMSSD over the last WINDOW beats.
// A beat that does not yet fill the window gives no word. A beat that leaves it full starts
// the statistics: two sweeps of the window RAM, five reciprocal divides and two 15-step
// square roots, then the result word; one beat is in work at a time, and a stalled result
// word holds the next beat off. Reset (rst, synchronous): empty window, pnn_threshold = 50;
// RAM is not cleared.
`default_nettype none

module hrv_window_statistics_unit import hrvws_pkg::*; #(
  parameter int WINDOW = 20
) (
  input  wire logic              clk,
  input  wire logic              rst,
  hrvws_in_if.sink               beats,
  hrvws_out_if.source            stats,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  // Pointer into the window, count up to WINDOW, running sum, pass count
  localparam int PW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = $clog2(BEAT_MAX * WINDOW + 1);
  localparam int NW = $clog2(WINDOW);
  // Divider dividend: the largest of the sums of squares and the scaled sums
  localparam int DW = $clog2(SQ_MAX * WINDOW + 1);

  localparam logic [PW-1:0] LAST_PTR = PW'(WINDOW - 1);
  localparam logic [CW-1:0] WIN_C    = CW'(WINDOW);

  hrvws_state_t state, state_next;
  logic         launch;

  logic              accept;
  logic [PW-1:0]     wp, wp_inc, wp_next;
  logic [CW-1:0]     fill, fill_next;
  logic [PW-1:0]     rptr, rptr_inc;
  logic [CW-1:0]     cnt;
  logic              in_pass;
  logic              consume;
  logic [BEAT_W-1:0] rd_data;
  logic [BEAT_W-1:0] prev;
  logic [BEAT_W-1:0] ad;
  logic signed [9:0] dev;
  logic [9:0]        dev_neg;
  logic [BEAT_W-1:0] adev;
  logic [BEAT_W-1:0] mul_a;
  logic [15:0]       sq;

  logic [SW-1:0]     sum;
  logic [DW-1:0]     sq_diff;
  logic [DW-1:0]     sq_dev;
  logic [NW-1:0]     npass;
  logic [BEAT_W-1:0] q8;
  logic              rnz;
  logic [MEAN_W-1:0] mean_r;
  logic [SDNN_W-1:0] sdnn_r;
  logic [RESP_W-1:0] resp_hold;
  logic [THR_W-1:0]  thr;

  logic                div_start, div_done;
  logic [DW-1:0]       div_dividend, div_quo;
  logic                div_by_m1;
  logic [CW-1:0]       div_rem;
  logic                sqrt_start, sqrt_done;
  logic [SQ_IN_W-1:0]  sqrt_rad;
  logic [SQ_OUT_W-1:0] sqrt_root;

  logic out_valid;
  logic load_out;
  logic cfg_write;

  // ---------------------------------------------------------------------------
  // Configuration port: one register, pnn_threshold, at word 0
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PNN_THR);
  assign prdata    = (paddr[2] == REG_PNN_THR) ? APB_DW'(thr) : '0;

  // ---------------------------------------------------------------------------
  // Window storage. Writes happen only when a beat is taken in idle; read data is used
  // only during the two sweeps, so a used read never meets a write to the same entry.
  // ---------------------------------------------------------------------------
  hrvws_ram #(
    .WIDTH (BEAT_W),
    .DEPTH (WINDOW)
  ) u_window (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (beats.beat_value),
    .raddr (rptr),
    .rdata (rd_data)
  );

  hrvws_div #(
    .DW      (DW),
    .VW      (CW),
    .DIVISOR (WINDOW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .by_m1     (div_by_m1),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  hrvws_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // ---------------------------------------------------------------------------
  // Pointers and window fill
  // ---------------------------------------------------------------------------
  assign accept    = beats.valid && beats.ready;
  assign wp_inc    = (wp == LAST_PTR) ? '0 : wp + PW'(1);
  assign wp_next   = accept ? wp_inc : wp;
  assign fill_next = (accept && fill != WIN_C) ? fill + CW'(1) : fill;
  assign rptr_inc  = (rptr == LAST_PTR) ? '0 : rptr + PW'(1);

  // ---------------------------------------------------------------------------
  // Sweep datapath. A sweep issues reads at cnt 0..WINDOW-1 starting from the
  // oldest entry and consumes RAM data at cnt 1..WINDOW. One 8x8 squarer
  // serves both sweeps: successive differences first, deviations second.
  // ---------------------------------------------------------------------------
  assign in_pass = (state == ST_PASS1) || (state == ST_PASS2);
  assign consume = in_pass && (cnt != '0);

  always_comb begin
    ad = (rd_data >= prev) ? rd_data - prev : prev - rd_data;
    // Deviation x - sum/WINDOW truncated toward zero: with a nonzero remainder
    // a positive difference drops by one, a non-positive one stays.
    dev = $signed({2'b00, rd_data}) - $signed({2'b00, q8});
    if (rnz && (rd_data > q8)) begin
      dev = dev - 10'sd1;
    end
    dev_neg = -dev;
    adev    = dev[9] ? dev_neg[BEAT_W-1:0] : dev[BEAT_W-1:0];
    mul_a   = (state == ST_PASS1) ? ad : adev;
    sq      = 16'(mul_a) * 16'(mul_a);
  end

  // ---------------------------------------------------------------------------
  // Divider and square root operands
  // ---------------------------------------------------------------------------
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_by_m1    = 1'b0;
    unique case (state)
      ST_DIV_Q: begin
        div_start    = launch;
        div_dividend = DW'(sum);
      end
      ST_DIV_MEAN: begin
        div_start    = launch;
        div_dividend = DW'(sum) * DW'(MEAN_SCALE);
      end
      ST_DIV_SD: begin
        div_start    = launch;
        div_dividend = sq_dev;
      end
      ST_DIV_RM: begin
        div_start    = launch;
        div_dividend = sq_diff;
        div_by_m1    = 1'b1;
      end
      ST_DIV_PNN: begin
        div_start    = launch;
        div_dividend = DW'(npass) * DW'(PNN_SCALE);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // The quotient register holds the mean square until the next divide starts
  assign sqrt_start = launch && ((state == ST_SQRT_SD) || (state == ST_SQRT_RM));
  assign sqrt_rad   = SQ_IN_W'(div_quo[QW-1:0]) * SQ_IN_W'(RAD_SCALE);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      launch    <= 1'b0;
      wp        <= '0;
      fill      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      thr       <= THR_RESET;
    end else begin
      state     <= state_next;
      launch    <= (state_next != state);
      wp        <= wp_next;
      fill      <= fill_next;
      out_valid <= load_out || (out_valid && !stats.ready);
      if (cfg_write) begin
        thr <= pwdata[THR_W-1:0];
      end
      if (state_next != state) begin
        cnt <= '0;
      end else if (in_pass && cnt != WIN_C) begin
        cnt <= cnt + CW'(1);
      end
    end
  end

  always_comb begin
    state_next  = state;
    beats.ready = 1'b0;
    load_out    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // Hold ready low while in reset so no word is taken and dropped
        beats.ready = !rst;
        // Only a beat that leaves the window full starts the statistics
        if (accept && fill_next == WIN_C) begin
          state_next = ST_PASS1;
        end
      end
      ST_PASS1:    if (cnt == WIN_C) state_next = ST_DIV_Q;
      ST_DIV_Q:    if (div_done) state_next = ST_DIV_MEAN;
      ST_DIV_MEAN: if (div_done) state_next = ST_PASS2;
      ST_PASS2:    if (cnt == WIN_C) state_next = ST_DIV_SD;
      ST_DIV_SD:   if (div_done) state_next = ST_SQRT_SD;
      ST_SQRT_SD:  if (sqrt_done) state_next = ST_DIV_RM;
      ST_DIV_RM:   if (div_done) state_next = ST_SQRT_RM;
      ST_SQRT_RM:  if (sqrt_done) state_next = ST_DIV_PNN;
      ST_DIV_PNN:  if (div_done) state_next = ST_DONE;
      ST_DONE: begin
        // Hold until the output register is free or drains this cycle
        if (!out_valid || stats.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      resp_hold <= beats.resp_rate;
    end

    // Start each sweep at the oldest entry, which is the next write slot
    if (state_next != state) begin
      rptr <= wp_next;
    end else if (in_pass) begin
      rptr <= rptr_inc;
    end

    if (state == ST_PASS1) begin
      if (cnt == '0) begin
        sum     <= '0;
        sq_diff <= '0;
        npass   <= '0;
      end else begin
        sum  <= sum + SW'(rd_data);
        prev <= rd_data;
        // Successive differences start with the second entry
        if (cnt >= CW'(2)) begin
          sq_diff <= sq_diff + DW'(sq);
          if (ad > thr) begin
            npass <= npass + NW'(1);
          end
        end
      end
    end

    if (state == ST_PASS2) begin
      if (cnt == '0) begin
        sq_dev <= '0;
      end else if (consume) begin
        sq_dev <= sq_dev + DW'(sq);
      end
    end

    if (state == ST_DIV_Q && div_done) begin
      q8  <= div_quo[BEAT_W-1:0];
      rnz <= (div_rem != '0);
    end
    if (state == ST_DIV_MEAN && div_done) begin
      mean_r <= div_quo[MEAN_W-1:0];
    end
    if (state == ST_SQRT_SD && sqrt_done) begin
      sdnn_r <= sqrt_root;
    end

    // Output register: RMSSD and pNN are still held by their units here
    if (load_out) begin
      stats.mean_x100  <= mean_r;
      stats.sdnn_x100  <= sdnn_r;
      stats.pnn_x100   <= div_quo[PNN_W-1:0];
      stats.rmssd_x100 <= sqrt_root;
      stats.resp_out   <= resp_hold;
    end
  end

  assign stats.valid = out_valid;

endmodule

`default_nettype wire
